@@ hw/rtl/spbd_pkg.sv @@
// ----------------------------------------------------------------------------
// spbd_pkg
// Shared constants and types for the splitmix bounded draw generator.
// ----------------------------------------------------------------------------
package spbd_pkg;

    localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
    localparam logic [31:0] LOW32_MASK  = 32'hFFFFFFFF;

    // request kinds
    localparam logic [2:0] MODE_RAW64  = 3'd0;
    localparam logic [2:0] MODE_HIGH32 = 3'd1;
    localparam logic [2:0] MODE_BELOW  = 3'd2;
    localparam logic [2:0] MODE_RANGE  = 3'd3;
    localparam logic [2:0] MODE_FRAC24 = 3'd4;
    localparam logic [2:0] MODE_CHANCE = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_SEED   = 2'd0;
    localparam logic [1:0] CFG_SALT   = 2'd1;
    localparam logic [1:0] CFG_SALTED = 2'd2;

    // control from the sequencer to the finaliser unit
    typedef struct packed {
        logic start;
        logic pre_mul;   // multiply by the golden step before finalising
    } mix_ctl_t;

endpackage

@@ hw/rtl/spbd_mix.sv @@
// ----------------------------------------------------------------------------
// spbd_mix
// Iterative splitmix64 finaliser built around one 32x32 multiplier.
// Each 64-bit multiply mod 2^64 is built from three partial products, taken in turn.
// ----------------------------------------------------------------------------
module spbd_mix
    import spbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mix_ctl_t    ctl,
    input  logic [63:0] x_in,
    output logic        done,
    output logic [63:0] result
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_PMUL,
        M_X30,
        M_MA,
        M_MB,
        M_DONE
    } mix_state_t;

    mix_state_t  state_reg;
    logic [1:0]  phase_reg;
    logic [63:0] x_reg;
    logic [63:0] acc_reg;

    logic [63:0] k;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] prod;

    always_comb
    begin
        case (state_reg)
            M_PMUL:  k = GOLDEN_STEP;
            M_MA:    k = MIX_MUL_A;
            default: k = MIX_MUL_B;
        endcase
        // phase 0: lo*lo, phase 1: lo*hi, phase 2: hi*lo
        mul_a = (phase_reg == 2'd2) ? x_reg[63:32] : x_reg[31:0];
        mul_b = (phase_reg == 2'd1) ? k[63:32] : k[31:0];
        mul_p = {32'b0, mul_a} * {32'b0, mul_b};
        prod  = {acc_reg[63:32] + mul_p[31:0], acc_reg[31:0]};
    end

    assign done   = (state_reg == M_DONE);
    assign result = x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            phase_reg <= 2'd0;
        end
        else
        begin
            case (state_reg)
                M_IDLE, M_DONE:
                begin
                    if (ctl.start)
                    begin
                        x_reg     <= x_in;
                        phase_reg <= 2'd0;
                        state_reg <= ctl.pre_mul ? M_PMUL : M_X30;
                    end
                    else
                    begin
                        state_reg <= M_IDLE;
                    end
                end
                M_X30:
                begin
                    x_reg     <= x_reg ^ (x_reg >> 30);
                    phase_reg <= 2'd0;
                    state_reg <= M_MA;
                end
                M_PMUL, M_MA, M_MB:
                begin
                    if (phase_reg == 2'd0)
                    begin
                        acc_reg   <= mul_p;
                        phase_reg <= 2'd1;
                    end
                    else if (phase_reg == 2'd1)
                    begin
                        acc_reg   <= prod;
                        phase_reg <= 2'd2;
                    end
                    else
                    begin
                        phase_reg <= 2'd0;
                        case (state_reg)
                            M_PMUL:
                            begin
                                x_reg     <= prod;
                                state_reg <= M_X30;
                            end
                            M_MA:
                            begin
                                x_reg     <= prod ^ (prod >> 27);
                                state_reg <= M_MB;
                            end
                            default:
                            begin
                                x_reg     <= prod ^ (prod >> 31);
                                state_reg <= M_DONE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/splitmix_bounded_draw_generator.sv @@
// ----------------------------------------------------------------------------
// splitmix_bounded_draw_generator
// Splitmix64 draws with Lemire bounded, signed range, fraction and chance modes.
// ----------------------------------------------------------------------------
// One draw: the result follows acceptance through the finaliser and its shared
// 32x32 multiplier. Bounded and non-full range modes add a product check, a
// bit-serial cut remainder on a near rejection, and a new draw per redraw.
// Zero bound, empty range, unused modes: result in the cycle after accept. One
// transaction in flight; the next waits until the result is taken. Reset clears
// seed, salt, salted, counter. Reload copies the seed, or salts and hashes it.
// ----------------------------------------------------------------------------
module splitmix_bounded_draw_generator
    import spbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,    // bound, range_low, range_high, probability, pad
    input  logic [2:0]   s_tuser,    // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,    // draw, signed_draw, hit, pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    typedef enum logic [2:0] {
        T_IDLE,
        T_LOAD,
        T_HASH1,
        T_HASH2,
        T_DRAW,
        T_WAIT,
        T_CHECK,
        T_DIV
    } state_t;

    state_t       state_reg;
    logic [63:0]  seed_reg;
    logic [63:0]  salt_reg;
    logic         salted_reg;
    logic [63:0]  counter_reg;

    logic [2:0]   mode_reg;
    logic [31:0]  limit_reg;
    logic [31:0]  lo_reg;
    logic [24:0]  prob_reg;
    logic         full_reg;
    logic         cut_ok_reg;
    logic [63:0]  prod_reg;
    logic [31:0]  rem_reg;
    logic [31:0]  quo_reg;
    logic [4:0]   div_cnt_reg;

    logic         m_tvalid_reg;
    logic [63:0]  out_draw_reg;
    logic [31:0]  out_sd_reg;
    logic         out_hit_reg;

    mix_ctl_t     mix_ctl;
    logic [63:0]  mix_x;
    logic         mix_done;
    logic [63:0]  mix_result;

    logic         s_accept;
    logic         cfg_accept;
    logic [31:0]  in_bound;
    logic [31:0]  in_lo;
    logic [31:0]  in_hi;
    logic [24:0]  in_prob;
    logic [32:0]  range_diff;
    logic         range_empty;
    logic         range_full;
    logic [63:0]  counter_step;
    logic [32:0]  div_trial;
    logic [32:0]  div_sub;
    logic [31:0]  lemire_val;

    assign cfg_ready  = (state_reg == T_IDLE);
    assign s_tready   = (state_reg == T_IDLE) && !m_tvalid_reg && !cfg_valid;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign in_bound = s_tdata[31:0];
    assign in_lo    = s_tdata[63:32];
    assign in_hi    = s_tdata[95:64];
    assign in_prob  = s_tdata[120:96];

    // signed hi - lo; negative or zero means empty range
    assign range_diff  = {in_hi[31], in_hi} - {in_lo[31], in_lo};
    assign range_empty = range_diff[32] || (range_diff == 33'd0);
    assign range_full  = !range_diff[32] && (range_diff[31:0] == LOW32_MASK);

    assign counter_step = counter_reg + GOLDEN_STEP;
    assign div_trial    = {rem_reg, quo_reg[31]};
    assign div_sub      = div_trial - {1'b0, limit_reg};
    assign lemire_val   = prod_reg[63:32];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_hit_reg, out_sd_reg, out_draw_reg};

    always_comb
    begin
        mix_ctl = '0;
        mix_x   = seed_reg;
        case (state_reg)
            T_LOAD:
            begin
                mix_ctl.start   = salted_reg;
                mix_ctl.pre_mul = 1'b1;
            end
            T_HASH1:
            begin
                mix_ctl.start = mix_done;
                mix_x         = salt_reg ^ mix_result;
            end
            T_DRAW:
            begin
                mix_ctl.start = 1'b1;
                mix_x         = counter_step;
            end
            default:
            begin
                mix_ctl = '0;
            end
        endcase
    end

    spbd_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mix_ctl),
        .x_in   (mix_x),
        .done   (mix_done),
        .result (mix_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            seed_reg     <= 64'd0;
            salt_reg     <= 64'd0;
            salted_reg   <= 1'b0;
            counter_reg  <= 64'd0;
            cut_ok_reg   <= 1'b0;
            div_cnt_reg  <= 5'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                T_IDLE:
                begin
                    if (cfg_accept)
                    begin
                        case (cfg_index)
                            CFG_SEED:
                            begin
                                seed_reg  <= cfg_data;
                                state_reg <= T_LOAD;
                            end
                            CFG_SALT:
                            begin
                                salt_reg  <= cfg_data;
                                state_reg <= T_LOAD;
                            end
                            CFG_SALTED:
                            begin
                                salted_reg <= cfg_data[0];
                                state_reg  <= T_LOAD;
                            end
                            default:
                            begin
                                state_reg <= T_IDLE;
                            end
                        endcase
                    end
                    else if (s_accept)
                    begin
                        mode_reg     <= s_tuser;
                        lo_reg       <= in_lo;
                        prob_reg     <= in_prob;
                        full_reg     <= range_full;
                        cut_ok_reg   <= 1'b0;
                        out_draw_reg <= 64'd0;
                        out_sd_reg   <= 32'd0;
                        out_hit_reg  <= 1'b0;
                        case (s_tuser)
                            MODE_BELOW:
                            begin
                                limit_reg <= in_bound;
                                if (in_bound == 32'd0)
                                begin
                                    m_tvalid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= T_DRAW;
                                end
                            end
                            MODE_RANGE:
                            begin
                                limit_reg <= range_diff[31:0] + 32'd1;
                                if (range_empty)
                                begin
                                    out_sd_reg   <= in_lo;
                                    m_tvalid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= T_DRAW;
                                end
                            end
                            MODE_RAW64, MODE_HIGH32, MODE_FRAC24, MODE_CHANCE:
                            begin
                                state_reg <= T_DRAW;
                            end
                            default:
                            begin
                                m_tvalid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                T_LOAD:
                begin
                    if (salted_reg)
                    begin
                        state_reg <= T_HASH1;
                    end
                    else
                    begin
                        counter_reg <= seed_reg;
                        state_reg   <= T_IDLE;
                    end
                end
                T_HASH1:
                begin
                    if (mix_done)
                    begin
                        state_reg <= T_HASH2;
                    end
                end
                T_HASH2:
                begin
                    if (mix_done)
                    begin
                        counter_reg <= mix_result;
                        state_reg   <= T_IDLE;
                    end
                end
                T_DRAW:
                begin
                    counter_reg <= counter_step;
                    state_reg   <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (mix_done)
                    begin
                        case (mode_reg)
                            MODE_RAW64:
                            begin
                                out_draw_reg <= mix_result;
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= T_IDLE;
                            end
                            MODE_HIGH32:
                            begin
                                out_draw_reg <= {32'd0, mix_result[63:32]};
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= T_IDLE;
                            end
                            MODE_FRAC24:
                            begin
                                out_draw_reg <= {40'd0, mix_result[63:40]};
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= T_IDLE;
                            end
                            MODE_CHANCE:
                            begin
                                out_hit_reg  <= ({1'b0, mix_result[63:40]} < prob_reg);
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= T_IDLE;
                            end
                            MODE_RANGE, MODE_BELOW:
                            begin
                                if ((mode_reg == MODE_RANGE) && full_reg)
                                begin
                                    out_sd_reg   <= lo_reg + mix_result[63:32];
                                    m_tvalid_reg <= 1'b1;
                                    state_reg    <= T_IDLE;
                                end
                                else
                                begin
                                    prod_reg  <= {32'd0, mix_result[63:32]}
                                                 * {32'd0, limit_reg};
                                    state_reg <= T_CHECK;
                                end
                            end
                            default:
                            begin
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= T_IDLE;
                            end
                        endcase
                    end
                end
                T_CHECK:
                begin
                    if (prod_reg[31:0] >= limit_reg
                        || (cut_ok_reg && prod_reg[31:0] >= rem_reg))
                    begin
                        if (mode_reg == MODE_BELOW)
                        begin
                            out_draw_reg <= {32'd0, lemire_val};
                        end
                        else
                        begin
                            out_sd_reg <= lo_reg + lemire_val;
                        end
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= T_IDLE;
                    end
                    else if (!cut_ok_reg)
                    begin
                        // cut = (2^32 - limit) mod limit, one quotient bit a cycle
                        rem_reg     <= 32'd0;
                        quo_reg     <= 32'd0 - limit_reg;
                        div_cnt_reg <= 5'd0;
                        state_reg   <= T_DIV;
                    end
                    else
                    begin
                        state_reg <= T_DRAW;
                    end
                end
                T_DIV:
                begin
                    rem_reg     <= div_sub[32] ? div_trial[31:0] : div_sub[31:0];
                    quo_reg     <= {quo_reg[30:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 5'd1;
                    if (div_cnt_reg == 5'd31)
                    begin
                        cut_ok_reg <= 1'b1;
                        state_reg  <= T_CHECK;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // a new request is never taken while a result is still held
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !m_tvalid_reg)
        else $error("input ready while output pending");

    // the finaliser only reports back to a state that waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mix_done |-> (state_reg == T_WAIT || state_reg == T_HASH1 || state_reg == T_HASH2))
        else $error("finaliser done in unexpected state");

    // the rejection cut is always below the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_CHECK && cut_ok_reg) |-> (rem_reg < limit_reg))
        else $error("cut not below limit");

    // a result appears only from an accepted request or the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(s_accept) || $past(state_reg) == T_WAIT
                                 || $past(state_reg) == T_CHECK))
        else $error("unexpected result");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the splitmix bounded draw generator. A directed table
// covers reset output, field extremes, zero bound, rejection-prone bounds,
// empty and full ranges, chance limits and unused modes. Random requests then
// run under several seed/salt settings, with random stalls on both stream sides.
// Results are checked against typed table values or a bit-exact generator model.
// ----------------------------------------------------------------------------
module tb;
    import spbd_pkg::*;

    localparam logic [2:0] MODE_UNUSED6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED7 = 3'd7;
    localparam logic [1:0] CFG_NONE     = 2'd3;   // index past the register list

    localparam int N_PHASES   = 8;
    localparam int PHASE_REQS = 125;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_WAIT  = 100;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] bound;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic [24:0] probability;
    } req_t;

    typedef struct packed {
        logic [63:0] draw;
        logic [31:0] signed_draw;
        logic        hit;
    } res_t;

    typedef struct {
        req_t req;
        bit   typed;
        res_t want;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    splitmix_bounded_draw_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // generator model state
    logic [63:0] gen_count = '0;
    logic [63:0] seed_q = '0;
    logic [63:0] salt_q = '0;
    logic        salted_q = 1'b0;

    res_t     pending_draws[$];
    dir_row_t dir_rows[$];
    int       errors = 0;
    int       mode_seen[8];
    int       cfg_writes = 0;
    int       idle_cycles = 0;
    int       sink_hold = 0;
    bit       calm = 1'b0;

    function automatic logic [63:0] finalise64(input logic [63:0] x);
        x = x ^ (x >> 30);
        x = x * MIX_MUL_A;
        x = x ^ (x >> 27);
        x = x * MIX_MUL_B;
        x = x ^ (x >> 31);
        return x;
    endfunction

    function automatic void reload_count();
        if (salted_q)
            gen_count = finalise64(salt_q ^ finalise64(seed_q * GOLDEN_STEP));
        else
            gen_count = seed_q;
    endfunction

    function automatic logic [63:0] next_draw();
        gen_count = gen_count + GOLDEN_STEP;
        return finalise64(gen_count);
    endfunction

    function automatic logic [31:0] next_draw32();
        logic [63:0] d;
        d = next_draw();
        return d[63:32];
    endfunction

    // Lemire multiply-and-reject; each rejected product costs another draw
    function automatic logic [31:0] draw_under(input logic [31:0] lim);
        logic [63:0] prod;
        logic [31:0] cut;
        if (lim == 32'd0)
            return 32'd0;
        prod = {32'd0, next_draw32()} * {32'd0, lim};
        if (prod[31:0] < lim) begin
            cut = (32'd0 - lim) % lim;
            while (prod[31:0] < cut)
                prod = {32'd0, next_draw32()} * {32'd0, lim};
        end
        return prod[63:32];
    endfunction

    function automatic res_t predict_request(input req_t r);
        res_t        p;
        logic [63:0] d;
        logic [32:0] span;
        p = '0;
        case (r.mode)
            MODE_RAW64:  p.draw = next_draw();
            MODE_HIGH32: p.draw = {32'd0, next_draw32()};
            MODE_BELOW:  p.draw = {32'd0, draw_under(r.bound)};
            MODE_RANGE: begin
                if ($signed(r.range_high) <= $signed(r.range_low)) begin
                    p.signed_draw = r.range_low;
                end else begin
                    span = {r.range_high[31], r.range_high}
                         - {r.range_low[31], r.range_low} + 33'd1;
                    if (span[32])
                        p.signed_draw = r.range_low + next_draw32();
                    else
                        p.signed_draw = r.range_low + draw_under(span[31:0]);
                end
            end
            MODE_FRAC24: begin
                d = next_draw();
                p.draw = {40'd0, d[63:40]};
            end
            MODE_CHANCE: begin
                d = next_draw();
                p.hit = ({1'b0, d[63:40]} < r.probability);
            end
            default: ;
        endcase
        return p;
    endfunction

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int gap_len();
        int pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic req_t rand_req();
        req_t        r;
        logic [31:0] rv;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick == 0)
            r.mode = MODE_UNUSED7;
        else if (pick < 3)
            r.mode = MODE_UNUSED6;
        else begin
            rv = $urandom_range(0, 5);
            r.mode = rv[2:0];
        end

        case ($urandom_range(0, 5))
            0: r.bound = $urandom_range(0, 16);
            1: r.bound = 32'h8000_0000 + $urandom_range(0, 15);   // heavy rejection
            2: begin
                rv = $urandom_range(0, 3);
                r.bound = (rv == 0) ? 32'd0 : (rv == 1) ? 32'd1 :
                          (rv == 2) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE;
            end
            default: r.bound = $urandom;
        endcase

        r.range_low = $urandom;
        case ($urandom_range(0, 5))
            0: r.range_high = r.range_low + $urandom_range(0, 20);
            1: begin
                r.range_low  = 32'h8000_0000;
                r.range_high = 32'h7FFF_FFFF;
            end
            2: r.range_high = r.range_low;
            3: r.range_high = r.range_low - $urandom_range(1, 20);
            4: begin
                r.range_low  = 32'h8000_0000 + $urandom_range(0, 3);
                r.range_high = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
            default: r.range_high = $urandom;
        endcase

        rv = $urandom;
        case ($urandom_range(0, 3))
            0: r.probability = rv[24:0];
            1: begin
                rv = $urandom_range(0, 3);
                r.probability = (rv == 0) ? 25'd0 : (rv == 1) ? 25'd1 :
                                (rv == 2) ? 25'h100_0000 : 25'h1FF_FFFF;
            end
            default: begin
                rv = $urandom_range(0, 32'h0100_0000);
                r.probability = rv[24:0];
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [2:0] mode, input logic [31:0] bound,
                           input logic [31:0] lo, input logic [31:0] hi,
                           input logic [24:0] prob, input bit typed,
                           input logic [63:0] w_draw, input logic [31:0] w_sd,
                           input logic w_hit);
        dir_row_t row;
        row.req   = '{mode: mode, bound: bound, range_low: lo, range_high: hi,
                      probability: prob};
        row.typed = typed;
        row.want  = '{draw: w_draw, signed_draw: w_sd, hit: w_hit};
        dir_rows.push_back(row);
    endtask

    // tvalid stays high after acceptance; the next call or hold_off moves it
    task automatic send_req(input req_t r, input int gap, input bit typed,
                            input res_t want);
        res_t p;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.probability, r.range_high, r.range_low, r.bound};
        s_tuser  <= r.mode;
        do @(posedge clk); while (!s_tready);
        p = predict_request(r);
        if (typed)
            p = want;
        pending_draws.push_back(p);
        mode_seen[r.mode]++;
    endtask

    task automatic hold_off();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_draws.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SEED:   seed_q   = val;
            CFG_SALT:   salt_q   = val;
            CFG_SALTED: salted_q = val[0];
            default: ;
        endcase
        if (idx != CFG_NONE)
            reload_count();
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup_phase(input int ph);
        case (ph)
            0: begin
                write_reg(CFG_SEED, 64'd0);
                write_reg(CFG_SALT, 64'd0);
                write_reg(CFG_SALTED, 64'd0);
            end
            1: write_reg(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
            2: begin
                write_reg(CFG_SALT, 64'hFFFF_FFFF_FFFF_FFFF);
                write_reg(CFG_SALTED, 64'd1);
            end
            3: begin
                write_reg(CFG_SEED, 64'd0);
                write_reg(CFG_SALT, 64'd0);
            end
            4: begin
                write_reg(CFG_SEED, {$urandom, $urandom});
                write_reg(CFG_SALT, {$urandom, $urandom});
                write_reg(CFG_SALTED, {$urandom, $urandom});
            end
            5: write_reg(CFG_NONE, {$urandom, $urandom});   // ignored, no reload
            6: begin
                write_reg(CFG_SALTED, 64'hFFFF_FFFF_FFFF_FFFE);   // bit 0 clear
                write_reg(CFG_SEED, {$urandom, $urandom});
            end
            default: begin
                write_reg(CFG_SEED, 64'd1);
                write_reg(CFG_SALT, 64'h8000_0000_0000_0000);
                write_reg(CFG_SALTED, 64'd1);
            end
        endcase
    endtask

    // result checker
    res_t got_res, want_res;

    task automatic report_miss(input string what, input res_t want, input res_t got);
        errors++;
        if (errors <= 10)
            $display("mismatch %0d (%s): expected draw=%h sd=%h hit=%b, got draw=%h sd=%h hit=%b",
                     errors, what, want.draw, want.signed_draw, want.hit,
                     got.draw, got.signed_draw, got.hit);
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            got_res.draw        = m_tdata[63:0];
            got_res.signed_draw = m_tdata[95:64];
            got_res.hit         = m_tdata[96];
            if (pending_draws.size() == 0) begin
                report_miss("unexpected result", '0, got_res);
            end else begin
                want_res = pending_draws.pop_front();
                if (got_res !== want_res)
                    report_miss("field mismatch", want_res, got_res);
            end
        end
    end

    // sink backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_hold <= gap_len();
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        int k;
        res_t none;
        none = '0;

        // first raw draw of a zero counter is known from the splitmix64 stream
        add_row(MODE_RAW64,   32'd0, 32'd0, 32'd0, 25'd0, 1, 64'hE220_A839_7B1D_CDAF, 32'd0, 1'b0);
        add_row(MODE_HIGH32,  32'd0, 32'd0, 32'd0, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_BELOW,   32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25'h1FF_FFFF,
                1, 64'd0, 32'd0, 1'b0);
        add_row(MODE_BELOW,   32'd1, 32'd0, 32'd0, 25'd0, 1, 64'd0, 32'd0, 1'b0);
        add_row(MODE_BELOW,   32'hFFFF_FFFF, 32'd0, 32'd0, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_BELOW,   32'h8000_0001, 32'd0, 32'd0, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_BELOW,   32'h8000_0000, 32'd0, 32'd0, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_BELOW,   32'd3, 32'd0, 32'd0, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_RANGE,   32'd0, 32'd5, 32'd5, 25'd0, 1, 64'd0, 32'd5, 1'b0);
        add_row(MODE_RANGE,   32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 25'd0,
                1, 64'd0, 32'h7FFF_FFFF, 1'b0);
        add_row(MODE_RANGE,   32'd0, 32'd0, 32'hFFFF_FFFF, 25'd0, 1, 64'd0, 32'd0, 1'b0);
        add_row(MODE_RANGE,   32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_RANGE,   32'd0, 32'h8000_0000, 32'h8000_0001, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_RANGE,   32'd0, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_RANGE,   32'd0, 32'hFFFF_FFF6, 32'd10, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_FRAC24,  32'd0, 32'd0, 32'd0, 25'd0, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_CHANCE,  32'd0, 32'd0, 32'd0, 25'd0, 1, 64'd0, 32'd0, 1'b0);
        add_row(MODE_CHANCE,  32'd0, 32'd0, 32'd0, 25'h100_0000, 1, 64'd0, 32'd0, 1'b1);
        add_row(MODE_CHANCE,  32'd0, 32'd0, 32'd0, 25'h1FF_FFFF, 1, 64'd0, 32'd0, 1'b1);
        add_row(MODE_CHANCE,  32'd0, 32'd0, 32'd0, 25'h080_0000, 0, 64'd0, 32'd0, 1'b0);
        add_row(MODE_UNUSED6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25'h1FF_FFFF,
                1, 64'd0, 32'd0, 1'b0);
        add_row(MODE_UNUSED7, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 25'h1FF_FFFF,
                1, 64'd0, 32'd0, 1'b0);
        add_row(MODE_RAW64,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 25'h1FF_FFFF,
                0, 64'd0, 32'd0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, gap_len(), dir_rows[i].typed, dir_rows[i].want);

        for (ph = 0; ph < N_PHASES; ph++) begin
            hold_off();
            calm = (ph % 3 == 2);
            setup_phase(ph);
            for (k = 0; k < PHASE_REQS; k++) begin
                if (k == PHASE_REQS / 2)
                    hold_off();   // let the pipe drain mid-phase
                send_req(rand_req(), gap_len(), 1'b0, none);
            end
        end

        hold_off();
        repeat (TAIL_WAIT) @(posedge clk);

        $display("covered requests raw=%0d high=%0d below=%0d range=%0d frac=%0d chance=%0d",
                 mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
                 mode_seen[4], mode_seen[5]);
        $display("unused-mode requests=%0d, register writes=%0d, mismatches=%0d",
                 mode_seen[6] + mode_seen[7], cfg_writes, errors);
        if (errors == 0 && pending_draws.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/spbd_pkg.sv
hw/rtl/spbd_mix.sv
hw/rtl/splitmix_bounded_draw_generator.sv
tb/tb.sv
